// ===== rtl/tsos_pkg.sv =====
// Shared types and constants for the timed stepper oscillation sequencer.
// No dependencies; used by every module under rtl/ except tsos_win_mem.
`default_nettype none

package tsos_pkg;

    localparam int MAX_WINDOWS_DEF = 8;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_MAX_PLAY  = 2'd1,
        CFG_STEPS     = 2'd2,
        CFG_WIN_COUNT = 2'd3
    } cfg_idx_t;

    localparam int CFG_DATA_W = 16;
    localparam int WCOUNT_W   = 4;

    localparam logic [15:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [15:0] MAX_PLAY_RST  = 16'd60;
    localparam logic [15:0] STEPS_RST     = 16'd100;
    localparam logic [3:0]  WIN_COUNT_RST = 4'd0;

    localparam int MS_PER_S = 1000;

    // Timeout threshold (max_play_s + 1) * 1000 fits in 27 bits
    localparam int THR_W = 27;
    localparam logic [THR_W-1:0] THR_RST = THR_W'((int'(MAX_PLAY_RST) + 1) * MS_PER_S);

    // secs = ((ms >> 3) * RECIP_125) >> DIV_SHIFT, exact for all 32-bit ms
    localparam int              DIV_SHIFT = 36;
    localparam int              RECIP_W   = 30;
    localparam logic [29:0]     RECIP_125 = 30'd549755814;
    localparam int              SECS_W    = 23;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_CW   = 2'd1,
        ACT_CCW  = 2'd2,
        ACT_OFF  = 2'd3
    } act_t;

    typedef struct packed {
        act_t        action;
        logic        run_active;
        logic [31:0] elapsed_ms;
        logic        run_started;
        logic        run_timed_out;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/tsos_win_mem.sv =====
// Window table: begin/end times, one write and one registered read a cycle.
// Write data is forwarded when it hits the address being read.
`default_nettype none

module tsos_win_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [31:0]       wr_begin,
    input  wire logic [31:0]       wr_end,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [31:0]       rd_begin,
    output logic      [31:0]       rd_end
);

    logic [31:0] begin_mem [DEPTH];
    logic [31:0] end_mem   [DEPTH];
    logic [31:0] rd_begin_reg;
    logic [31:0] rd_end_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            begin_mem[wr_addr] <= wr_begin;
            end_mem[wr_addr]   <= wr_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_begin_reg <= wr_begin;
            rd_end_reg   <= wr_end;
        end else begin
            rd_begin_reg <= begin_mem[rd_addr];
            rd_end_reg   <= end_mem[rd_addr];
        end
    end

    assign rd_begin = rd_begin_reg;
    assign rd_end   = rd_end_reg;

endmodule

`default_nettype wire

// ===== rtl/tsos_core.sv =====
// Sequencer state: config registers, debounce, run timing, window arming and
// the stepper oscillation. Uses tsos_pkg and tsos_win_mem.
`default_nettype none

module tsos_core #(
    parameter int MAX_WINDOWS = tsos_pkg::MAX_WINDOWS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [tsos_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                          step_en,
    input  wire logic                          kind,
    input  wire logic                          button_level,
    input  wire logic [31:0]                   now_ms,
    input  wire logic [2:0]                    window_slot,
    input  wire logic [31:0]                   window_begin_ms,
    input  wire logic [31:0]                   window_end_ms,
    output tsos_pkg::result_t                  res
);

    localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
    localparam int ADDR_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    // config
    logic [15:0]                  debounce_reg;
    logic [tsos_pkg::THR_W-1:0]   thr_reg;
    logic [15:0]                  steps_reg;
    logic [3:0]                   wcount_reg;

    // sequencer state
    logic        prev_reg, prev_next;
    logic        stable_reg, stable_next;
    logic [31:0] last_reg, last_next;
    logic        run_reg, run_next;
    logic        playing_reg, playing_next;
    logic [31:0] start_reg, start_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic        stop_reg, stop_next;
    logic        motor_reg, motor_next;
    logic        dir_cw_reg, dir_cw_next;
    logic [15:0] step_reg, step_next;

    logic [31:0] rd_begin, rd_end;
    logic        tick_en;
    logic        load_en;
    logic [CNT_W-1:0] nwin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= tsos_pkg::DEBOUNCE_RST;
            thr_reg      <= tsos_pkg::THR_RST;
            steps_reg    <= tsos_pkg::STEPS_RST;
            wcount_reg   <= tsos_pkg::WIN_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (tsos_pkg::cfg_idx_t'(cfg_addr))
                tsos_pkg::CFG_DEBOUNCE:  debounce_reg <= cfg_wdata;
                tsos_pkg::CFG_MAX_PLAY: begin
                    // timeout when elapsed_ms >= (max_play_s + 1) * 1000
                    thr_reg <= tsos_pkg::THR_W'(
                        (tsos_pkg::THR_W'(cfg_wdata) + tsos_pkg::THR_W'(1))
                        * tsos_pkg::THR_W'(tsos_pkg::MS_PER_S));
                end
                tsos_pkg::CFG_STEPS:     steps_reg  <= cfg_wdata;
                tsos_pkg::CFG_WIN_COUNT: wcount_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign nwin = (int'(wcount_reg) > MAX_WINDOWS) ? CNT_W'(MAX_WINDOWS)
                                                   : CNT_W'(wcount_reg);

    assign tick_en = step_en && !kind;
    assign load_en = step_en && kind && (int'(window_slot) < MAX_WINDOWS);

    tsos_win_mem #(
        .DEPTH  (MAX_WINDOWS),
        .ADDR_W (ADDR_W)
    ) u_win_mem (
        .aclk     (aclk),
        .wr_en    (load_en),
        .wr_addr  (ADDR_W'(window_slot)),
        .wr_begin (window_begin_ms),
        .wr_end   (window_end_ms),
        .rd_addr  (idx_next[ADDR_W-1:0]),
        .rd_begin (rd_begin),
        .rd_end   (rd_end)
    );

    always_comb begin
        logic        changed;
        logic        settle;
        logic        run1;
        logic        start;
        logic [31:0] elapsed;
        logic        tmo;
        logic        run2;
        logic [CNT_W-1:0] idx1;
        logic        motor2;
        logic        in_win;
        tsos_pkg::act_t action;

        changed = (button_level != prev_reg);
        settle  = !changed && ((now_ms - last_reg) > 32'(debounce_reg))
                  && (button_level != stable_reg);
        run1    = run_reg || (settle && !button_level);
        start   = run1 && !playing_reg;

        start_next = start ? now_ms : start_reg;
        elapsed    = now_ms - start_next;
        tmo        = run1 && (elapsed >= 32'(thr_reg));
        run2       = run1 && !tmo;

        prev_next    = button_level;
        stable_next  = settle ? button_level : stable_reg;
        last_next    = changed ? now_ms : last_reg;
        run_next     = run2;
        playing_next = (playing_reg || start) && !tmo;

        idx1       = tmo ? '0 : idx_reg;
        stop_next  = tmo ? 1'b0 : stop_reg;
        motor_next = tmo ? 1'b0 : motor_reg;
        step_next  = tmo ? '0 : step_reg;
        dir_cw_next = dir_cw_reg;
        action     = tmo ? tsos_pkg::ACT_OFF : tsos_pkg::ACT_NONE;

        in_win = (idx1 < nwin);
        motor2 = motor_next || (run2 && in_win
                 && (elapsed > rd_begin) && (elapsed < rd_end));
        motor_next = motor2;

        if (motor2) begin
            if (step_next < steps_reg) begin
                action    = dir_cw_reg ? tsos_pkg::ACT_CW : tsos_pkg::ACT_CCW;
                step_next = step_next + 16'd1;
            end else if (dir_cw_reg) begin
                step_next   = '0;
                dir_cw_next = 1'b0;
            end else if (stop_next) begin
                motor_next = 1'b0;
                action     = tsos_pkg::ACT_OFF;
                step_next  = '0;
            end else begin
                step_next   = '0;
                dir_cw_next = 1'b1;
            end
        end

        idx_next = idx1;
        if (run2 && motor_next && in_win && (elapsed > rd_end)) begin
            stop_next = 1'b1;
            idx_next  = idx1 + CNT_W'(1);
        end

        // read address follows the index only when a tick is taken
        if (!tick_en) begin
            idx_next = idx_reg;
        end

        if (kind) begin
            res.action        = tsos_pkg::ACT_NONE;
            res.run_active    = run_reg;
            res.elapsed_ms    = '0;
            res.run_started   = 1'b0;
            res.run_timed_out = 1'b0;
        end else begin
            res.action        = action;
            res.run_active    = run2;
            res.elapsed_ms    = elapsed;
            res.run_started   = start;
            res.run_timed_out = tmo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= 1'b1;
            stable_reg  <= 1'b1;
            last_reg    <= '0;
            run_reg     <= 1'b0;
            playing_reg <= 1'b0;
            start_reg   <= '0;
            idx_reg     <= '0;
            stop_reg    <= 1'b0;
            motor_reg   <= 1'b0;
            dir_cw_reg  <= 1'b1;
            step_reg    <= '0;
        end else if (tick_en) begin
            prev_reg    <= prev_next;
            stable_reg  <= stable_next;
            last_reg    <= last_next;
            run_reg     <= run_next;
            playing_reg <= playing_next;
            start_reg   <= start_next;
            idx_reg     <= idx_next;
            stop_reg    <= stop_next;
            motor_reg   <= motor_next;
            dir_cw_reg  <= dir_cw_next;
            step_reg    <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tsos_out.sv =====
// Output stage: converts elapsed ms to whole seconds by reciprocal multiply
// and holds the result transfer. Uses tsos_pkg.
`default_nettype none

module tsos_out (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire tsos_pkg::result_t in_res,
    output logic                   in_ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata
);

    localparam int Q_W    = 32 - 3;
    localparam int PROD_W = Q_W + tsos_pkg::RECIP_W;

    logic                        valid_reg;
    logic [1:0]                  action_reg;
    logic                        active_reg;
    logic [tsos_pkg::SECS_W-1:0] secs_reg;
    logic                        started_reg;
    logic                        tmo_reg;
    logic [PROD_W-1:0]           prod;

    // ms / 1000 = (ms / 8) / 125
    assign prod = PROD_W'(in_res.elapsed_ms[31:3]) * PROD_W'(tsos_pkg::RECIP_125);

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            action_reg  <= in_res.action;
            active_reg  <= in_res.run_active;
            secs_reg    <= prod[tsos_pkg::DIV_SHIFT + tsos_pkg::SECS_W - 1:tsos_pkg::DIV_SHIFT];
            started_reg <= in_res.run_started;
            tmo_reg     <= in_res.run_timed_out;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, tmo_reg, started_reg, secs_reg, active_reg, action_reg};

endmodule

`default_nettype wire

// ===== rtl/timed_stepper_oscillation_sequencer.sv =====
// Timed stepper oscillation sequencer, top level. Uses tsos_pkg, tsos_core, tsos_out.
// Result path: input register, state stage register, output register.
// Throughput: one item per cycle unless the result stream stalls; the whole state
// update for an item is combinational between the input and state stage registers.
// Reset (aresetn low, synchronous): pipeline empty, config back to defaults,
// run stopped, clockwise first. Window table contents are undefined until loaded.
`default_nettype none

module timed_stepper_oscillation_sequencer #(
    parameter int MAX_WINDOWS = tsos_pkg::MAX_WINDOWS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [15:0]  cfg_wdata,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [0] button_level, [32:1] now_ms, [35:33] window_slot,
    // [67:36] window_begin_ms, [99:68] window_end_ms, [103:100] zero
    input  wire logic [103:0] s_tdata,
    // [0] kind
    input  wire logic         s_tuser,
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [1:0] step_action, [2] run_active, [25:3] run_secs, [26] run_started,
    // [27] run_timed_out, [31:28] zero
    output logic [31:0]       m_tdata
);

    logic        a_valid_reg;
    logic        a_kind_reg;
    logic        a_level_reg;
    logic [31:0] a_now_reg;
    logic [2:0]  a_slot_reg;
    logic [31:0] a_begin_reg;
    logic [31:0] a_end_reg;

    logic              b_valid_reg;
    tsos_pkg::result_t b_res_reg;
    tsos_pkg::result_t core_res;

    logic c_ready;
    logic b_ready;
    logic a_fire;

    assign b_ready  = !b_valid_reg || c_ready;
    assign a_fire   = a_valid_reg && b_ready;
    assign s_tready = !a_valid_reg || b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            a_kind_reg  <= s_tuser;
            a_level_reg <= s_tdata[0];
            a_now_reg   <= s_tdata[32:1];
            a_slot_reg  <= s_tdata[35:33];
            a_begin_reg <= s_tdata[67:36];
            a_end_reg   <= s_tdata[99:68];
        end
    end

    tsos_core #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .step_en         (a_fire),
        .kind            (a_kind_reg),
        .button_level    (a_level_reg),
        .now_ms          (a_now_reg),
        .window_slot     (a_slot_reg),
        .window_begin_ms (a_begin_reg),
        .window_end_ms   (a_end_reg),
        .res             (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            b_res_reg <= core_res;
        end
    end

    tsos_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (b_valid_reg),
        .in_res   (b_res_reg),
        .in_ready (c_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== sim/tsos_checker.sv =====
// Checker for the timed stepper oscillation sequencer: watches the config port and both
// streams, predicts each result and compares it field by field. Depends on tsos_pkg.
module tsos_checker
    import tsos_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    output int           mismatches,
    output int           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // same bit order as m_tdata[27:0]
    typedef struct packed {
        logic        timed_out;
        logic        started;
        logic [22:0] secs;
        logic        active;
        act_t        action;
    } step_report_t;

    localparam int WIN_SLOTS = MAX_WINDOWS_DEF;

    logic [15:0] debounce_ms, max_play_s, steps_per_dir;
    logic [3:0]  win_count;
    logic        prev_lvl, stable_lvl, run_on, playing, stop_req, motor_on, dir_cw;
    logic [31:0] last_edge_ms, run_start_ms;
    logic [3:0]  win_idx;
    logic [15:0] step_cnt;
    logic [31:0] win_open  [WIN_SLOTS];
    logic [31:0] win_close [WIN_SLOTS];
    step_report_t report_q[$];

    function automatic void clear_sequencer();
        debounce_ms   = DEBOUNCE_RST;
        max_play_s    = MAX_PLAY_RST;
        steps_per_dir = STEPS_RST;
        win_count     = WIN_COUNT_RST;
        prev_lvl      = 1'b1;
        stable_lvl    = 1'b1;
        last_edge_ms  = '0;
        run_on        = 1'b0;
        playing       = 1'b0;
        run_start_ms  = '0;
        win_idx       = '0;
        stop_req      = 1'b0;
        motor_on      = 1'b0;
        dir_cw        = 1'b1;
        step_cnt      = '0;
    endfunction

    function automatic step_report_t advance_sequencer(input logic is_load, input logic lvl,
            input logic [31:0] now, input logic [2:0] slot, input logic [31:0] open_ms,
            input logic [31:0] close_ms);
        step_report_t r;
        logic [31:0]  since_edge, elapsed, secs;
        logic [3:0]   nwin;
        r = '0;
        if (is_load) begin
            win_open[slot]  = open_ms;
            win_close[slot] = close_ms;
            r.active = run_on;
            return r;
        end

        // debounce: a level is taken once it has held for more than debounce_ms
        if (lvl != prev_lvl)
            last_edge_ms = now;
        since_edge = now - last_edge_ms;
        if (since_edge > 32'(debounce_ms) && lvl != stable_lvl) begin
            stable_lvl = lvl;
            if (!lvl)
                run_on = 1'b1;
        end
        prev_lvl = lvl;

        if (run_on && !playing) begin
            run_start_ms = now;
            playing      = 1'b1;
            r.started    = 1'b1;
        end

        elapsed = now - run_start_ms;
        secs    = elapsed / 32'd1000;

        if (run_on && secs > 32'(max_play_s)) begin
            run_on      = 1'b0;
            playing     = 1'b0;
            win_idx     = '0;
            stop_req    = 1'b0;
            motor_on    = 1'b0;
            step_cnt    = '0;
            r.action    = ACT_OFF;
            r.timed_out = 1'b1;
        end

        nwin = (win_count > 4'(WIN_SLOTS)) ? 4'(WIN_SLOTS) : win_count;

        if (run_on && !motor_on && win_idx < nwin && elapsed > win_open[win_idx[2:0]] &&
            elapsed < win_close[win_idx[2:0]])
            motor_on = 1'b1;

        if (motor_on) begin
            if (dir_cw) begin
                if (step_cnt < steps_per_dir) begin
                    r.action = ACT_CW;
                    step_cnt++;
                end else begin
                    step_cnt = '0;
                    dir_cw   = 1'b0;
                end
            end else if (step_cnt < steps_per_dir) begin
                r.action = ACT_CCW;
                step_cnt++;
            end else if (stop_req) begin
                motor_on = 1'b0;
                r.action = ACT_OFF;
                step_cnt = '0;
            end else begin
                step_cnt = '0;
                dir_cw   = 1'b1;
            end
        end

        // stop request stays set until the next timeout
        if (run_on && motor_on && win_idx < nwin && elapsed > win_close[win_idx[2:0]]) begin
            stop_req = 1'b1;
            win_idx++;
        end

        r.active = run_on;
        r.secs   = secs[22:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        step_report_t want, got;
        if (!aresetn) begin
            clear_sequencer();
            report_q.delete();
            mismatches = 0;
        end else begin
            // pop before push so a result never meets its own item's prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata[27:0];
                if (report_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result %h", $time, m_tdata);
                end else begin
                    want = report_q.pop_front();
                    if (got.action !== want.action || got.active !== want.active ||
                        got.secs !== want.secs || got.started !== want.started ||
                        got.timed_out !== want.timed_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp act=%0d run=%0b s=%0d st=%0b to=%0b %s",
                                     $time, want.action, want.active, want.secs, want.started,
                                     want.timed_out, $sformatf("got act=%0d run=%0b s=%0d st=%0b to=%0b",
                                     got.action, got.active, got.secs, got.started, got.timed_out));
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_DEBOUNCE:  debounce_ms   = cfg_wdata;
                    CFG_MAX_PLAY:  max_play_s    = cfg_wdata;
                    CFG_STEPS:     steps_per_dir = cfg_wdata;
                    CFG_WIN_COUNT: win_count     = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                report_q.push_back(advance_sequencer(s_tuser, s_tdata[0], s_tdata[32:1],
                                                     s_tdata[35:33], s_tdata[67:36],
                                                     s_tdata[99:68]));
        end
        outstanding = report_q.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the sequencer testbench: clock, reset, stimulus, ready stalls and the verdict.
// Depends on tsos_pkg, the sequencer RTL and tsos_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tsos_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          PHASES      = 13;
    localparam int          PHASE_ITEMS = 140;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_addr  = '0;
    logic [15:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b1;
    logic [31:0]  m_tdata;
    int           mismatches, outstanding;

    int unsigned  cycles     = 0;
    int           stall_left = 0;
    int           calm_left  = 0;
    bit           calm_out   = 1'b0;
    bit           calm_in    = 1'b0;

    // button / wall-clock model for the random part
    logic [31:0]  wall_ms   = '0;
    logic [31:0]  hold_left = '0;
    logic         btn_lvl   = 1'b1;

    timed_stepper_oscillation_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tsos_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result-side stalls, with calm stretches in between
    always @(negedge aclk) begin
        if (calm_left == 0) begin
            calm_out  = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(50, 400);
        end else begin
            calm_left--;
        end
        if (stall_left == 0 && !calm_out)
            stall_left = idle_len();
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic kind, input logic lvl, input logic [31:0] now,
                             input logic [2:0] slot, input logic [31:0] open_ms,
                             input logic [31:0] close_ms);
        int gap;
        gap = calm_in ? 0 : idle_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, close_ms, open_ms, slot, now, lvl};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_tick(input logic lvl, input logic [31:0] now);
        send_item(1'b0, lvl, now, 3'($urandom), $urandom, $urandom);
    endtask

    task automatic send_load(input logic [2:0] slot, input logic [31:0] open_ms,
                             input logic [31:0] close_ms);
        send_item(1'b1, 1'($urandom), $urandom, slot, open_ms, close_ms);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // registers change only with the pipeline drained
    task automatic write_config(input logic [15:0] deb, input logic [15:0] play,
                                input logic [15:0] steps, input logic [3:0] wc);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_MAX_PLAY, play);
        write_reg(CFG_STEPS, steps);
        write_reg(CFG_WIN_COUNT, 16'(wc));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input logic [31:0] dt_max,
                             input logic [31:0] win_span, input logic [31:0] deb);
        logic [31:0] dt, open_ms;
        logic        lvl;
        int          r;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 6) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_load(3'($urandom), $urandom, $urandom);
                end else begin
                    open_ms = $urandom_range(0, win_span);
                    send_load(3'($urandom), open_ms,
                              open_ms + $urandom_range(0, win_span / 2 + 1));
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    dt = '0;
                else if (r < 4)
                    dt = $urandom;
                else
                    dt = $urandom_range(1, dt_max);
                wall_ms += dt;
                if (hold_left <= dt) begin
                    btn_lvl   = ~btn_lvl;
                    // mostly holds long enough to be taken, some bounces
                    hold_left = ($urandom_range(0, 6) == 0) ? $urandom_range(0, deb / 2)
                                : deb + $urandom_range(1, 4 * dt_max);
                end else begin
                    hold_left -= dt;
                end
                lvl = ($urandom_range(0, 29) == 0) ? ~btn_lvl : btn_lvl;
                send_tick(lvl, wall_ms);
            end
        end
    endtask

    initial begin
        logic [31:0] t0, run0, run_ms, dt_max;
        logic [15:0] deb, play, steps;
        logic [3:0]  wc;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // fill the whole window table before any window is in use
        send_load(3'd0, 32'd0, 32'd250);
        send_load(3'd1, 32'd350, 32'd600);
        send_load(3'd2, 32'd0, 32'd0);
        send_load(3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int s = 4; s < 8; s++)
            send_load(3'(s), $urandom, $urandom);
        write_config(16'd5, 16'd1, 16'd1, 4'd2);

        // press just before the ms counter wraps, short bounce first
        t0 = 32'hFFFF_FE00;
        send_tick(1'b1, t0);
        send_tick(1'b0, t0 + 1);
        send_tick(1'b0, t0 + 4);
        run0 = t0 + 9;
        send_tick(1'b0, run0);
        // first window: cw/ccw halves, stop request, finish ccw and off;
        // second window: one ccw half then off; release on the way
        for (int k = 1; k <= 12; k++) begin
            send_tick(k < 6 ? 1'b0 : 1'b1, run0 + 60 * k);
            if (k == 7)
                send_load(3'd4, $urandom, $urandom);
        end
        send_tick(1'b1, run0 + 2100);
        send_tick(1'b1, run0 + 2500);
        wall_ms = run0 + 2500;

        for (int p = 0; p < PHASES; p++) begin
            deb   = (p == 1) ? 16'hFFFF : (p == 2) ? 16'd0 : 16'($urandom_range(0, 40));
            play  = (p == 3) ? 16'hFFFF : (p == 4) ? 16'd0 : 16'($urandom_range(1, 4));
            steps = (p == 5) ? 16'hFFFF : (p == 6) ? 16'd0 : 16'($urandom_range(0, 6));
            wc    = (p == 7) ? 4'd15 : (p == 8) ? 4'd0 : (p == 9) ? 4'd8
                    : 4'($urandom_range(1, 8));
            write_config(deb, play, steps, wc);
            calm_in = (p % 4 == 3);
            run_ms  = 32'd1000 * (32'(play) + 1);
            dt_max  = 1 + ((32'(deb) + run_ms) >> 5);
            run_phase(PHASE_ITEMS, dt_max, run_ms, 32'(deb));
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
